>>> rtl/core/stcs_pkg.sv
// Shared types and constants for the sorted table ceiling search block.
// Used by the channel interfaces, the register file, the search engine and the top level.
// No dependencies.
package stcs_pkg;

    // Field widths of the request and response channels
    localparam int OP_W     = 1;
    localparam int SLOT_W   = 10;
    localparam int KEY_W    = 32;
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 11;

    // APB register space: one word per register
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Request operation codes
    localparam logic [OP_W-1:0] OP_WRITE  = 1'b0;
    localparam logic [OP_W-1:0] OP_SEARCH = 1'b1;

    // Response status codes
    localparam logic STATUS_FOUND = 1'b0;
    localparam logic STATUS_NONE  = 1'b1;

    // Register indexes, taken from paddr[2]
    localparam logic REG_ENTRY_COUNT    = 1'b0;
    localparam logic REG_COMPARE_SIGNED = 1'b1;

    // Configuration handed from the register file to the search engine
    typedef struct packed {
        logic [COUNT_W-1:0] entry_count;
        logic               compare_signed;
    } cfg_t;

endpackage

>>> rtl/core/stcs_if.sv
// Valid/ready channel interfaces for search requests and search responses.
// Depends on stcs_pkg for the field widths.
interface stcs_req_if;
    logic                       valid;
    logic                       ready;
    logic [stcs_pkg::OP_W-1:0]   op;
    logic [stcs_pkg::SLOT_W-1:0] slot;
    logic [stcs_pkg::KEY_W-1:0]  key;

    modport source (output valid, output op, output slot, output key, input ready);
    modport sink   (input valid, input op, input slot, input key, output ready);
endinterface

interface stcs_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic                        exact;
    logic [stcs_pkg::INDEX_W-1:0] found_index;
    logic [stcs_pkg::KEY_W-1:0]   found_value;

    modport source (output valid, output status, output exact, output found_index,
                    output found_value, input ready);
    modport sink   (input valid, input status, input exact, input found_index,
                    input found_value, output ready);
endinterface

>>> rtl/core/stcs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module stcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write when we is set and read every cycle; read data lands in the next cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/stcs_cfg_regs.sv
// APB register file: entry count and compare mode for the search engine.
// Depends on stcs_pkg for register indexes and the cfg_t struct.
module stcs_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stcs_pkg::PADDR_W-1:0]  paddr,
    input  logic [stcs_pkg::PDATA_W-1:0]  pwdata,
    output logic [stcs_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output stcs_pkg::cfg_t                cfg
);

    logic [stcs_pkg::COUNT_W-1:0] entry_count_reg;
    logic                         compare_signed_reg;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Write the addressed register in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg    <= '0;
            compare_signed_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            if (paddr[2] == stcs_pkg::REG_ENTRY_COUNT)
            begin
                entry_count_reg <= pwdata[stcs_pkg::COUNT_W-1:0];
            end
            else
            begin
                compare_signed_reg <= pwdata[0];
            end
        end
    end

    // Return the addressed register on reads
    always_comb
    begin
        if (paddr[2] == stcs_pkg::REG_COMPARE_SIGNED)
        begin
            prdata = stcs_pkg::PDATA_W'(compare_signed_reg);
        end
        else
        begin
            prdata = stcs_pkg::PDATA_W'(entry_count_reg);
        end
    end

    assign cfg.entry_count    = entry_count_reg;
    assign cfg.compare_signed = compare_signed_reg;

endmodule

>>> rtl/core/stcs_search.sv
// Search engine: table RAM, probe sequencer and response register.
// Depends on stcs_pkg, stcs_req_if, stcs_rsp_if and stcs_ram.
module stcs_search #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  stcs_pkg::cfg_t cfg,
    stcs_req_if.sink       req,
    stcs_rsp_if.source     rsp
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int BND_W = IDX_W + 1;
    localparam int CMP_W = (BND_W > stcs_pkg::COUNT_W) ? BND_W : stcs_pkg::COUNT_W;
    localparam logic [KEY_WIDTH-1:0] SIGN_MASK = {1'b1, {(KEY_WIDTH-1){1'b0}}};

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // Midpoint of the half-open window [lo, hi), lo < hi
    function automatic logic [IDX_W-1:0] mid_of(input logic [BND_W-1:0] lo,
                                                 input logic [BND_W-1:0] hi);
        logic [BND_W:0] sum;
        sum = {1'b0, lo} + {1'b0, hi} - (BND_W + 1)'(1);
        return sum[IDX_W:1];
    endfunction

    logic [1:0]           state_reg, state_next;
    logic [BND_W-1:0]     lo_reg, lo_next;
    logic [BND_W-1:0]     hi_reg, hi_next;
    logic [IDX_W-1:0]     mid_reg, mid_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic                 have_reg, have_next;
    logic                 exact_reg, exact_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [KEY_WIDTH-1:0] best_val_reg, best_val_next;

    logic                         rsp_valid_reg, rsp_valid_next;
    logic                         rsp_status_reg, rsp_status_next;
    logic                         rsp_exact_reg, rsp_exact_next;
    logic [stcs_pkg::INDEX_W-1:0] rsp_index_reg, rsp_index_next;
    logic [stcs_pkg::KEY_W-1:0]   rsp_value_reg, rsp_value_next;

    logic                 req_fire;
    logic                 slot_ok;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_raddr;
    logic [KEY_WIDTH-1:0] ram_rdata;
    logic [CMP_W-1:0]     count_ext;
    logic [BND_W-1:0]     count_clamped;
    logic [KEY_WIDTH-1:0] key_cmp, entry_cmp;
    logic                 key_lt, key_eq;
    logic                 out_free;

    // Accept requests only while no search is in flight
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;

    // Drop writes to slots beyond the table
    assign slot_ok = (32'(req.slot) < 32'(TABLE_DEPTH));
    assign ram_we  = req_fire && (req.op == stcs_pkg::OP_WRITE) && slot_ok;

    stcs_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IDX_W'(req.slot)),
        .wdata (KEY_WIDTH'(req.key)),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Clamp the configured entry count to the table depth
    assign count_ext     = CMP_W'(cfg.entry_count);
    assign count_clamped = (count_ext > CMP_W'(TABLE_DEPTH)) ? BND_W'(TABLE_DEPTH)
                                                             : count_ext[BND_W-1:0];

    // Compare key against the probed entry; flip sign bits for signed mode
    assign key_cmp   = cfg.compare_signed ? (key_reg ^ SIGN_MASK) : key_reg;
    assign entry_cmp = cfg.compare_signed ? (ram_rdata ^ SIGN_MASK) : ram_rdata;
    assign key_lt    = key_cmp < entry_cmp;
    assign key_eq    = key_cmp == entry_cmp;

    assign out_free = !rsp_valid_reg || rsp.ready;

    // Probe sequencer: one RAM read per probe, next address from this compare
    always_comb
    begin
        state_next    = state_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        key_next      = key_reg;
        have_next     = have_reg;
        exact_next    = exact_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        ram_raddr     = mid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.op == stcs_pkg::OP_SEARCH))
                begin
                    lo_next       = '0;
                    hi_next       = count_clamped;
                    key_next      = KEY_WIDTH'(req.key);
                    have_next     = 1'b0;
                    exact_next    = 1'b0;
                    best_idx_next = '0;
                    best_val_next = '0;
                    state_next    = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_raddr  = mid_of(lo_reg, hi_reg);
                    mid_next   = ram_raddr;
                    state_next = ST_CHECK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CHECK:
            begin
                if (key_eq)
                begin
                    have_next     = 1'b1;
                    exact_next    = 1'b1;
                    best_idx_next = mid_reg;
                    best_val_next = ram_rdata;
                    state_next    = ST_DONE;
                end
                else
                begin
                    if (key_lt)
                    begin
                        have_next     = 1'b1;
                        best_idx_next = mid_reg;
                        best_val_next = ram_rdata;
                        hi_next       = {1'b0, mid_reg};
                    end
                    else
                    begin
                        lo_next = {1'b0, mid_reg} + BND_W'(1);
                    end
                    if (lo_next < hi_next)
                    begin
                        ram_raddr = mid_of(lo_next, hi_next);
                        mid_next  = ram_raddr;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Load the response register when a result is done and the slot is free
    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_exact_next  = rsp_exact_reg;
        rsp_index_next  = rsp_index_reg;
        rsp_value_next  = rsp_value_reg;
        if ((state_reg == ST_DONE) && out_free)
        begin
            rsp_valid_next  = 1'b1;
            rsp_status_next = have_reg ? stcs_pkg::STATUS_FOUND : stcs_pkg::STATUS_NONE;
            rsp_exact_next  = exact_reg;
            rsp_index_next  = stcs_pkg::INDEX_W'(best_idx_reg);
            rsp_value_next  = stcs_pkg::KEY_W'(best_val_reg);
        end
    end

    // Hold control state under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Advance search and response payload
    always_ff @(posedge clk)
    begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        key_reg        <= key_next;
        have_reg       <= have_next;
        exact_reg      <= exact_next;
        best_idx_reg   <= best_idx_next;
        best_val_reg   <= best_val_next;
        rsp_status_reg <= rsp_status_next;
        rsp_exact_reg  <= rsp_exact_next;
        rsp_index_reg  <= rsp_index_next;
        rsp_value_reg  <= rsp_value_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.exact       = rsp_exact_reg;
    assign rsp.found_index = rsp_index_reg;
    assign rsp.found_value = rsp_value_reg;

    // Table writes never overlap a search's reads
    a_no_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !ram_we)
        else $error("table write during search");

    // A probe always has a non-empty window
    a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> (lo_reg < hi_reg))
        else $error("probe with empty window");

    // A not-exist response carries zero fields
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (rsp_status_reg == stcs_pkg::STATUS_NONE)) |->
        (!rsp_exact_reg && (rsp_index_reg == '0) && (rsp_value_reg == '0)))
        else $error("not-exist response with nonzero fields");

    // A finished search leaves the done state only by loading a response
    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && out_free) |=> rsp_valid_reg)
        else $error("search result lost");

endmodule

>>> rtl/core/sorted_table_ceiling_search.sv
// Top level of the sorted table ceiling search block: APB registers and search engine.
// Depends on stcs_pkg, stcs_req_if, stcs_rsp_if, stcs_cfg_regs and stcs_search.
//
// A write request stores its key into one table slot; slots at or above TABLE_DEPTH are
// dropped. A search request runs a lower-bound binary search over the first entry_count
// entries in p probes, where p is at most ceil(log2(count + 1)), 11 for a full
// 1024-entry table. A new request is accepted only once the search has loaded its
// response register. Each probe is one read of the table RAM whose address comes from
// the previous compare, so the RAM read latency paces the search. A finished response
// waits in an output register while the next request is accepted. The table is not
// cleared at reset: entries read as undefined until written.
module sorted_table_ceiling_search #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    stcs_req_if.sink                      req,
    stcs_rsp_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stcs_pkg::PADDR_W-1:0]  paddr,
    input  logic [stcs_pkg::PDATA_W-1:0]  pwdata,
    output logic [stcs_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    stcs_pkg::cfg_t cfg;

    // Configuration registers
    stcs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Table and search sequencer
    stcs_search #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

>>> bench/sorted_table_ceiling_search_test.sv
// Self-checking testbench for the sorted table ceiling search block.
// Drives write and search requests, predicts each lower-bound result and checks the responses.
// Depends on stcs_pkg, stcs_req_if, stcs_rsp_if and sorted_table_ceiling_search.
module sorted_table_ceiling_search_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH     = 1024;
    localparam int STALL_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 30;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int COUNT_MAX       = (1 << stcs_pkg::COUNT_W) - 1;

    typedef struct packed {
        logic                         status;
        logic                         exact;
        logic [stcs_pkg::INDEX_W-1:0] found_index;
        logic [stcs_pkg::KEY_W-1:0]   found_value;
    } search_result_t;

    logic                         clk     = 1'b0;
    logic                         rst_n   = 1'b0;
    logic                         psel    = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite  = 1'b0;
    logic [stcs_pkg::PADDR_W-1:0] paddr   = '0;
    logic [stcs_pkg::PDATA_W-1:0] pwdata  = '0;
    logic [stcs_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    stcs_req_if req_ch ();
    stcs_rsp_if rsp_ch ();

    sorted_table_ceiling_search uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the table and the registers
    logic [stcs_pkg::KEY_W-1:0]   entry_shadow [TABLE_DEPTH];
    logic [stcs_pkg::COUNT_W-1:0] count_shadow  = '0;
    logic                         signed_shadow = 1'b0;

    search_result_t expected_results [$];

    int items_sent     = 0;
    int fail_count     = 0;
    int filled_upto    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_off_left  = 0;
    int quiet_cycles   = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Order two keys under the current compare mode: -1, 0 or 1
    function automatic int key_order(logic [stcs_pkg::KEY_W-1:0] a,
                                     logic [stcs_pkg::KEY_W-1:0] b);
        logic [stcs_pkg::KEY_W-1:0] ba;
        logic [stcs_pkg::KEY_W-1:0] bb;
        ba = a;
        bb = b;
        if (signed_shadow)
        begin
            ba[stcs_pkg::KEY_W-1] = ~ba[stcs_pkg::KEY_W-1];
            bb[stcs_pkg::KEY_W-1] = ~bb[stcs_pkg::KEY_W-1];
        end
        if (ba < bb)
            return -1;
        if (ba > bb)
            return 1;
        return 0;
    endfunction

    function automatic int active_span();
        return (count_shadow > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_shadow);
    endfunction

    // Walk the same probe path as the block and return the ceiling or exact hit
    function automatic search_result_t predict_search(logic [stcs_pkg::KEY_W-1:0] key);
        search_result_t res;
        int lo;
        int hi;
        int mid;
        int ord;
        int pick;
        bit have;
        bit hit;
        lo   = 0;
        hi   = active_span() - 1;
        have = 1'b0;
        hit  = 1'b0;
        pick = 0;
        while (lo <= hi && !hit)
        begin
            mid = (lo + hi) >> 1;
            ord = key_order(key, entry_shadow[mid]);
            if (ord < 0)
            begin
                have = 1'b1;
                pick = mid;
                hi   = mid - 1;
            end
            else if (ord > 0)
                lo = mid + 1;
            else
            begin
                have = 1'b1;
                hit  = 1'b1;
                pick = mid;
            end
        end
        if (!have)
        begin
            res.status      = stcs_pkg::STATUS_NONE;
            res.exact       = 1'b0;
            res.found_index = '0;
            res.found_value = '0;
        end
        else
        begin
            res.status      = stcs_pkg::STATUS_FOUND;
            res.exact       = hit;
            res.found_index = pick[stcs_pkg::INDEX_W-1:0];
            res.found_value = entry_shadow[pick];
        end
        return res;
    endfunction

    function automatic logic [stcs_pkg::KEY_W-1:0] pick_extreme_key();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return 32'h7FFF_FFFF;
            default: return 32'h8000_0000;
        endcase
    endfunction

    // Favor keys that land on, next to, or between live entries
    function automatic logic [stcs_pkg::KEY_W-1:0] pick_probe_key();
        logic [stcs_pkg::KEY_W-1:0] base;
        if (active_span() == 0)
            return ($urandom_range(1) == 0) ? pick_extreme_key()
                                            : stcs_pkg::KEY_W'($urandom);
        base = entry_shadow[$urandom_range(active_span() - 1)];
        case ($urandom_range(9))
            0, 1, 2, 3: return base;
            4: return base + 1'b1;
            5: return base - 1'b1;
            6: return pick_extreme_key();
            default: return stcs_pkg::KEY_W'($urandom);
        endcase
    endfunction

    function automatic logic [stcs_pkg::KEY_W-1:0] make_entry_value(int style);
        case (style)
            0: return stcs_pkg::KEY_W'($urandom);
            1: return stcs_pkg::KEY_W'($urandom_range(63));
            2: return stcs_pkg::KEY_W'(int'($urandom_range(63)) - 32);
            default: return ($urandom_range(7) == 0) ? pick_extreme_key()
                                                     : stcs_pkg::KEY_W'($urandom);
        endcase
    endfunction

    // Offer one request and update the shadow state when it is taken
    task automatic send_request(logic [stcs_pkg::OP_W-1:0] op,
                                logic [stcs_pkg::SLOT_W-1:0] slot,
                                logic [stcs_pkg::KEY_W-1:0] key);
        if (items_sent < 650)
        begin
            send_idle_pct = 22;
            recv_idle_pct = 61;
        end
        else if (items_sent < 1300)
        begin
            send_idle_pct = 61;
            recv_idle_pct = 22;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.op    = op;
        req_ch.slot  = slot;
        req_ch.key   = key;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        if (op == stcs_pkg::OP_SEARCH)
            expected_results.push_back(predict_search(key));
        else
            entry_shadow[slot] = key;
        items_sent++;
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic search_request();
        send_request(stcs_pkg::OP_SEARCH,
                     stcs_pkg::SLOT_W'($urandom_range(TABLE_DEPTH - 1)),
                     pick_probe_key());
    endtask

    // Drain all pending searches, then let any trailing write finish
    task automatic wait_for_idle();
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic reg_sel, logic [stcs_pkg::PDATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_sel, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (reg_sel == stcs_pkg::REG_ENTRY_COUNT)
            count_shadow = value[stcs_pkg::COUNT_W-1:0];
        else
            signed_shadow = value[0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic write_config(int count_value, bit signed_mode);
        wait_for_idle();
        write_register(stcs_pkg::REG_ENTRY_COUNT, stcs_pkg::PDATA_W'(count_value));
        write_register(stcs_pkg::REG_COMPARE_SIGNED, stcs_pkg::PDATA_W'(signed_mode));
    endtask

    // Load a sorted table of the given size, then search it with a few stray writes mixed in
    task automatic run_table_phase(int entries, int count_value, bit signed_mode,
                                   int searches);
        bit [stcs_pkg::KEY_W-1:0]   vals [$];
        logic [stcs_pkg::KEY_W-1:0] bias;
        int                         style;
        bit                         descending;
        int                         slot_now;
        write_config(count_value, signed_mode);
        bias  = signed_mode ? 32'h8000_0000 : '0;
        style = $urandom_range(3);
        for (int i = 0; i < entries; i++)
            vals.push_back(make_entry_value(style) ^ bias);
        vals.sort();
        descending = 1'($urandom_range(1));
        for (int i = 0; i < entries; i++)
        begin
            slot_now = descending ? entries - 1 - i : i;
            send_request(stcs_pkg::OP_WRITE, stcs_pkg::SLOT_W'(slot_now),
                         vals[slot_now] ^ bias);
        end
        if (entries > filled_upto)
            filled_upto = entries;
        for (int i = 0; i < searches; i++)
        begin
            if ($urandom_range(19) == 0)
                send_request(stcs_pkg::OP_WRITE,
                             stcs_pkg::SLOT_W'($urandom_range(TABLE_DEPTH - 1)),
                             stcs_pkg::KEY_W'($urandom));
            else
                search_request();
        end
    endtask

    task automatic test_empty_table();
        // Reset count is zero: nothing can be found
        send_request(stcs_pkg::OP_SEARCH, '1, '0);
        send_request(stcs_pkg::OP_SEARCH, '0, '1);
    endtask

    task automatic test_small_sorted_table();
        send_request(stcs_pkg::OP_WRITE, 10'd0, 32'h0000_0005);
        send_request(stcs_pkg::OP_WRITE, 10'd1, 32'h0000_0010);
        send_request(stcs_pkg::OP_WRITE, 10'd2, 32'h0000_0100);
        send_request(stcs_pkg::OP_WRITE, 10'd3, 32'h7FFF_FFFF);
        send_request(stcs_pkg::OP_WRITE, 10'd4, 32'h8000_0000);
        send_request(stcs_pkg::OP_WRITE, 10'd5, 32'hC000_0000);
        send_request(stcs_pkg::OP_WRITE, 10'd6, 32'hFFFF_FFF0);
        send_request(stcs_pkg::OP_WRITE, 10'd7, 32'hFFFF_FFFF);
        filled_upto = 8;
        write_config(8, 1'b0);
        send_request(stcs_pkg::OP_SEARCH, '0, 32'h0000_0000);
        send_request(stcs_pkg::OP_SEARCH, '0, 32'h0000_0010);
        send_request(stcs_pkg::OP_SEARCH, '1, 32'h0000_0011);
        send_request(stcs_pkg::OP_SEARCH, '0, 32'hFFFF_FFFF);
        send_request(stcs_pkg::OP_SEARCH, '0, 32'h8000_0001);
    endtask

    task automatic test_signed_compare_unsorted();
        // Same table read as two's complement is out of order
        write_config(8, 1'b1);
        send_request(stcs_pkg::OP_SEARCH, '0, 32'h8000_0000);
        send_request(stcs_pkg::OP_SEARCH, '0, 32'hFFFF_FFFF);
        send_request(stcs_pkg::OP_SEARCH, '0, 32'h0000_0005);
    endtask

    task automatic test_single_entry();
        write_config(1, 1'b0);
        send_request(stcs_pkg::OP_SEARCH, '0, 32'h0000_0006);
        send_request(stcs_pkg::OP_SEARCH, '0, 32'h0000_0005);
        send_request(stcs_pkg::OP_SEARCH, '0, 32'h0000_0000);
    endtask

    task automatic test_receiver_hold_off();
        // Stall responses long enough that the block backs up into its input
        write_config(8, 1'b0);
        hold_off_left = HOLD_OFF_CYCLES;
        repeat (12) search_request();
    endtask

    task automatic test_random_small_tables(int item_goal);
        int entries;
        int count_value;
        int reach;
        while (items_sent < item_goal)
        begin
            entries = ($urandom_range(9) == 0) ? $urandom_range(64, 160) : $urandom_range(1, 24);
            reach   = (filled_upto > entries) ? filled_upto : entries;
            case ($urandom_range(9))
                0: count_value = 0;
                1: count_value = $urandom_range(entries);
                2: count_value = $urandom_range(reach);
                default: count_value = entries;
            endcase
            run_table_phase(entries, count_value, 1'($urandom_range(1)),
                            $urandom_range(10, 30));
        end
    endtask

    task automatic test_full_table();
        run_table_phase(TABLE_DEPTH, TABLE_DEPTH, 1'($urandom_range(1)), 60);
    endtask

    task automatic test_clamped_count();
        // Counts above the table depth search the whole table
        run_table_phase(0, COUNT_MAX, signed_shadow, 40);
    endtask

    // Response ready: random stalls, or a counted hold-off when one is requested
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                rsp_ch.ready = 1'b0;
                hold_off_left--;
            end
            else
                rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_response();
        search_result_t want;
        if (expected_results.size() == 0)
        begin
            $error("unexpected response: status %0d exact %0d index %0d value %h",
                   rsp_ch.status, rsp_ch.exact, rsp_ch.found_index, rsp_ch.found_value);
            fail_count++;
            return;
        end
        want = expected_results.pop_front();
        if (rsp_ch.status !== want.status)
        begin
            $error("status expected %0d actual %0d", want.status, rsp_ch.status);
            fail_count++;
        end
        if (rsp_ch.exact !== want.exact)
        begin
            $error("exact expected %0d actual %0d", want.exact, rsp_ch.exact);
            fail_count++;
        end
        if (rsp_ch.found_index !== want.found_index)
        begin
            $error("found_index expected %0d actual %0d", want.found_index, rsp_ch.found_index);
            fail_count++;
        end
        if (rsp_ch.found_value !== want.found_value)
        begin
            $error("found_value expected %h actual %h", want.found_value, rsp_ch.found_value);
            fail_count++;
        end
    endtask

    // Check every response taken at a rising edge
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            check_response();
    end

    // Stop a run that makes no progress on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.op    = stcs_pkg::OP_WRITE;
        req_ch.slot  = '0;
        req_ch.key   = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_small_sorted_table();
        test_signed_compare_unsorted();
        test_single_entry();
        test_receiver_hold_off();
        test_random_small_tables(600);
        test_full_table();
        test_clamped_count();
        test_random_small_tables(1950);

        wait_for_idle();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
